[rtl/core/ght_pkg.sv]
// Shared types and codes for the generational handle table.
package ght_pkg;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_RESOLVE  = 2'd1,
		CMD_RELEASE  = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_STALE     = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BS_INIT,
		BS_IDLE,
		BS_MATCH,
		BS_FREE,
		BS_GEN,
		BS_CHECK,
		BS_CLEAR
	} bstate_t;

	localparam int unsigned PREFIX_LSB = 24;
	localparam int unsigned REG_PREFIX = 0;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] value;
		logic [31:0] handle;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [31:0] value_out;
	} result_t;

	typedef struct packed {
		cmd_t        op;
		logic        bad;
		logic [31:0] value;
		logic [15:0] gen;
		logic [7:0]  slot;
	} job_t;

endpackage

[rtl/core/generational_handle_table_unit.sv]
// Generational handle table: top level with configuration port.
// One command is taken when start is high and busy is low; each produces one result
// on the result port, flagged by done for a single cycle, which the receiver cannot stall.
// A two-entry queue sits between intake and execution, so up to two commands may be taken
// while one is carried out. Resolve and release finish sooner when the handle fails the
// prefix, generation or range check at intake; clear reads and rewrites every generation
// slot by slot; register compares the stored values and, when none matches, walks the
// occupancy bits for a free slot, one slot per cycle in both the value compare and the
// free search. After reset, busy stays high while every generation is set to one;
// configuration writes are taken during that time.
module generational_handle_table_unit
	import ght_pkg::*;
#(
	parameter int CAPACITY   = 256,
	parameter int SLOT_BITS  = 8,
	parameter int GEN_BITS   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] prefix_q;
	logic       push, pop, q_full, q_empty, init_busy;
	job_t       job, qdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'(REG_PREFIX)) ? 32'(prefix_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 8'd165;
		end else if (psel && penable && pwrite && paddr[2] == 1'(REG_PREFIX)) begin
			prefix_q <= pwdata[7:0];
		end
	end

	ght_front #(
		.CAPACITY(CAPACITY), .SLOT_BITS(SLOT_BITS), .GEN_BITS(GEN_BITS)
	) u_front (
		.start(start), .item(item), .prefix(prefix_q), .q_full(q_full),
		.init_busy(init_busy), .busy(busy), .push(push), .job(job)
	);

	ght_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(job), .pop(pop),
		.rdata(qdata), .full(q_full), .empty(q_empty)
	);

	ght_back #(
		.CAPACITY(CAPACITY), .SLOT_BITS(SLOT_BITS), .GEN_BITS(GEN_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .prefix(prefix_q), .qdata(qdata),
		.empty(q_empty), .pop(pop), .init_busy(init_busy), .done(done),
		.result(result)
	);
endmodule

[rtl/core/ght_front.sv]
// Command intake: accepts transactions and checks handle fields.
module ght_front
	import ght_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int SLOT_BITS = 8,
	parameter int GEN_BITS  = 16
) (
	input  logic       start,
	input  item_t      item,
	input  logic [7:0] prefix,
	input  logic       q_full,
	input  logic       init_busy,
	output logic       busy,
	output logic       push,
	output job_t       job
);
	localparam logic [8:0] CAP9 = 9'(CAPACITY);

	logic [GEN_BITS-1:0]  gen_f;
	logic [SLOT_BITS-1:0] slot_f;

	assign gen_f  = item.handle[SLOT_BITS +: GEN_BITS];
	assign slot_f = item.handle[SLOT_BITS-1:0];
	assign busy   = q_full | init_busy;
	assign push   = start & ~busy;

	always_comb begin
		job.op    = cmd_t'(item.command);
		job.value = item.value;
		job.gen   = 16'(gen_f);
		job.slot  = 8'(slot_f);
		job.bad   = (item.handle[31:PREFIX_LSB] != prefix) || (gen_f == '0) ||
			({1'b0, job.slot} >= CAP9);
	end
endmodule

[rtl/core/ght_queue.sv]
// Two-entry job queue between intake and execution.
module ght_queue
	import ght_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic empty
);
	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[rtl/core/ght_back.sv]
// Command execution: slot stores, scans and result register.
module ght_back
	import ght_pkg::*;
#(
	parameter int CAPACITY   = 256,
	parameter int SLOT_BITS  = 8,
	parameter int GEN_BITS   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] prefix,
	input  job_t       qdata,
	input  logic       empty,
	output logic       pop,
	output logic       init_busy,
	output logic       done,
	output result_t    result
);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(CAPACITY - 1);

	logic [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [GEN_BITS-1:0]   gen_mem [CAPACITY];
	logic [CAPACITY-1:0]   occ_q;

	bstate_t state_q, state_d;
	job_t    job_q;
	logic [IDX_W-1:0] idx_q, cmp_idx_q, slot_q, sstart_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cmp_v_q;
	logic             emit_q;
	logic [VALUE_BITS-1:0] val_rd_q;
	logic [GEN_BITS-1:0]   gen_rd_q;

	logic                  val_we, gen_we;
	logic [IDX_W-1:0]      val_wa, val_ra, gen_wa, gen_ra;
	logic [VALUE_BITS-1:0] val_wd;
	logic [GEN_BITS-1:0]   gen_wd;
	logic                  emit;
	result_t               emit_res;

	logic [63:0]           key64;
	logic [VALUE_BITS-1:0] key;
	logic [IDX_W-1:0]      jslot;
	logic                  hit, chk_ok, issuing;
	logic [GEN_BITS-1:0]   gen_adv;
	logic [31:0]           hbuild;
	logic [63:0]           vout64;

	function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] x);
		inc_idx = (x == LAST) ? '0 : x + IDX_W'(1);
	endfunction

	assign key64   = 64'(job_q.value);
	assign key     = key64[VALUE_BITS-1:0];
	assign jslot   = job_q.slot[IDX_W-1:0];
	assign issuing = (cnt_q != CAP_C);
	assign hit     = cmp_v_q && occ_q[cmp_idx_q] && (val_rd_q == key);
	assign chk_ok  = occ_q[jslot] && (gen_rd_q == job_q.gen[GEN_BITS-1:0]);
	assign gen_adv = (&gen_rd_q) ? GEN_BITS'(1) : gen_rd_q + GEN_BITS'(1);
	assign vout64  = 64'(val_rd_q);
	assign init_busy = (state_q == BS_INIT);
	assign done    = emit_q;

	always_comb begin
		hbuild = '0;
		hbuild[31:PREFIX_LSB] = prefix;
		hbuild[SLOT_BITS +: GEN_BITS] = gen_rd_q;
		hbuild[IDX_W-1:0] = slot_q;
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wa] <= val_wd;
		end
		val_rd_q <= val_mem[val_ra];
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_wa] <= gen_wd;
		end
		gen_rd_q <= gen_mem[gen_ra];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_INIT: begin
				if (idx_q == LAST) begin
					state_d = BS_IDLE;
				end
			end
			BS_IDLE: begin
				if (!empty) begin
					case (qdata.op)
						CMD_REGISTER: state_d = BS_MATCH;
						CMD_CLEAR:    state_d = BS_CLEAR;
						default:      state_d = qdata.bad ? BS_IDLE : BS_CHECK;
					endcase
				end
			end
			BS_MATCH: begin
				if (hit) begin
					state_d = BS_GEN;
				end else if (cmp_v_q && cmp_idx_q == LAST) begin
					state_d = BS_FREE;
				end
			end
			BS_FREE: begin
				if (!occ_q[idx_q]) begin
					state_d = BS_GEN;
				end else if (cnt_q == CAP_M1) begin
					state_d = BS_IDLE;
				end
			end
			BS_GEN:   state_d = BS_IDLE;
			BS_CHECK: state_d = BS_IDLE;
			BS_CLEAR: begin
				if (cmp_v_q && cmp_idx_q == LAST) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		val_we   = 1'b0;
		val_wa   = idx_q;
		val_wd   = key;
		val_ra   = idx_q;
		gen_we   = 1'b0;
		gen_wa   = idx_q;
		gen_wd   = gen_adv;
		gen_ra   = idx_q;
		emit     = 1'b0;
		emit_res = '0;
		case (state_q)
			BS_INIT: begin
				gen_we = 1'b1;
				gen_wd = GEN_BITS'(1);
			end
			BS_IDLE: begin
				pop    = !empty;
				val_ra = qdata.slot[IDX_W-1:0];
				gen_ra = qdata.slot[IDX_W-1:0];
				if (!empty && qdata.bad &&
					(qdata.op == CMD_RESOLVE || qdata.op == CMD_RELEASE)) begin
					emit = 1'b1;
					emit_res.status = ST_INVALID;
				end
			end
			BS_MATCH: begin
				gen_ra = cmp_idx_q;
			end
			BS_FREE: begin
				gen_ra = idx_q;
				if (!occ_q[idx_q]) begin
					val_we = 1'b1;
				end else if (cnt_q == CAP_M1) begin
					emit = 1'b1;
					emit_res.status = ST_EXHAUSTED;
				end
			end
			BS_GEN: begin
				emit = 1'b1;
				emit_res.status = ST_OK;
				emit_res.handle_out = hbuild;
			end
			BS_CHECK: begin
				emit = 1'b1;
				if (!chk_ok) begin
					emit_res.status = ST_STALE;
				end else if (job_q.op == CMD_RESOLVE) begin
					emit_res.value_out = vout64[31:0];
				end else begin
					gen_we = 1'b1;
					gen_wa = jslot;
				end
			end
			BS_CLEAR: begin
				gen_ra = idx_q;
				gen_wa = cmp_idx_q;
				gen_we = cmp_v_q;
				if (cmp_v_q && cmp_idx_q == LAST) begin
					emit = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= qdata;
		end
		if (emit) begin
			result <= emit_res;
		end
		cmp_idx_q <= idx_q;
		if (state_q == BS_MATCH && hit) begin
			slot_q <= cmp_idx_q;
		end else if (state_q == BS_FREE) begin
			slot_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BS_INIT;
			idx_q    <= '0;
			cnt_q    <= '0;
			cmp_v_q  <= 1'b0;
			occ_q    <= '0;
			sstart_q <= '0;
			emit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_q  <= emit;
			cmp_v_q <= (state_q == BS_MATCH || state_q == BS_CLEAR) && issuing;
			case (state_q)
				BS_INIT: begin
					idx_q <= inc_idx(idx_q);
				end
				BS_IDLE: begin
					idx_q <= '0;
					cnt_q <= '0;
					if (!empty && qdata.op == CMD_CLEAR) begin
						occ_q    <= '0;
						sstart_q <= '0;
					end
				end
				BS_MATCH, BS_CLEAR: begin
					if (state_q == BS_MATCH && !hit && cmp_v_q && cmp_idx_q == LAST) begin
						idx_q <= sstart_q;
						cnt_q <= '0;
					end else if (issuing) begin
						idx_q <= inc_idx(idx_q);
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				BS_FREE: begin
					if (!occ_q[idx_q]) begin
						occ_q[idx_q] <= 1'b1;
						sstart_q     <= inc_idx(idx_q);
					end else begin
						idx_q <= inc_idx(idx_q);
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				BS_CHECK: begin
					if (chk_ok && job_q.op == CMD_RELEASE) begin
						occ_q[jslot] <= 1'b0;
						sstart_q     <= jslot;
					end
				end
				default: ;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_clear_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_IDLE && !empty && qdata.op == CMD_CLEAR) |=> (occ_q == '0))
		else $error("clear left occupied slots");

	a_release_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_CHECK && chk_ok && job_q.op == CMD_RELEASE) |=>
		!occ_q[$past(jslot)])
		else $error("release left slot occupied");

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !emit)
		else $error("result during initialization");
endmodule

[sim/generational_handle_table_unit_tb.sv]
// Self-checking testbench for the generational handle table unit.
`timescale 1ns / 100ps
module generational_handle_table_unit_tb;
	import ght_pkg::*;

	localparam int SLOTS = 256;
	localparam int DRAIN = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic done;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	generational_handle_table_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// table shadow
	logic [7:0] tag;
	logic [31:0] shadow_value [SLOTS];
	logic shadow_used [SLOTS];
	logic [15:0] shadow_gen [SLOTS];
	logic [7:0] next_free;

	result_t pending_results [$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int exhausted_seen = 0;
	int stale_seen = 0;
	int invalid_seen = 0;

	typedef struct {
		cmd_t op;
		logic [31:0] value;
		logic [31:0] handle;
		bit typed;
		result_t res;
	} row_t;

	function automatic logic [15:0] next_gen(logic [15:0] g);
		return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
	endfunction

	function automatic logic [31:0] pack_handle(logic [7:0] s, logic [15:0] g);
		return {tag, g, s};
	endfunction

	task automatic table_apply(input item_t it, output result_t r);
		logic [15:0] g;
		logic [7:0] s;
		logic [7:0] k;
		bit hit;
		r = '0;
		hit = 0;
		g = it.handle[23:8];
		s = it.handle[7:0];
		case (cmd_t'(it.command))
			CMD_REGISTER: begin
				for (int i = 0; i < SLOTS && !hit; i++) begin
					if (shadow_used[i] && shadow_value[i] == it.value) begin
						r.handle_out = pack_handle(i[7:0], shadow_gen[i]);
						hit = 1;
					end
				end
				for (int i = 0; i < SLOTS && !hit; i++) begin
					k = next_free + i[7:0];
					if (!shadow_used[k]) begin
						if (shadow_gen[k] == 16'd0)
							shadow_gen[k] = 16'd1;
						shadow_value[k] = it.value;
						shadow_used[k] = 1'b1;
						next_free = k + 8'd1;
						r.handle_out = pack_handle(k, shadow_gen[k]);
						hit = 1;
					end
				end
				if (!hit)
					r.status = ST_EXHAUSTED;
			end
			CMD_RESOLVE, CMD_RELEASE: begin
				if (it.handle[31:24] != tag || g == 16'd0)
					r.status = ST_INVALID;
				else if (!shadow_used[s] || shadow_gen[s] != g)
					r.status = ST_STALE;
				else if (it.command == CMD_RESOLVE)
					r.value_out = shadow_value[s];
				else begin
					shadow_value[s] = '0;
					shadow_used[s] = 1'b0;
					shadow_gen[s] = next_gen(shadow_gen[s]);
					next_free = s;
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++) begin
					shadow_value[i] = '0;
					shadow_used[i] = 1'b0;
					shadow_gen[i] = next_gen(shadow_gen[i]);
				end
				next_free = '0;
			end
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("unexpected transaction", '0, result.handle_out);
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (result.status != want.status)
					report("status", 32'(want.status), 32'(result.status));
				if (result.handle_out != want.handle_out)
					report("handle_out", want.handle_out, result.handle_out);
				if (result.value_out != want.value_out)
					report("value_out", want.value_out, result.value_out);
				case (result.status)
					ST_EXHAUSTED: exhausted_seen++;
					ST_STALE: stale_seen++;
					ST_INVALID: invalid_seen++;
					default: ;
				endcase
			end
		end
	end

	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 70) begin
			start <= 1'b0;
			repeat (r < 95 ? $urandom_range(1, 4) : $urandom_range(20, 400)) @(posedge clk);
		end
	endtask

	// hold the transaction until the unit takes it
	task automatic send(input item_t it, input bit typed, input result_t typed_res);
		result_t r;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		table_apply(it, r);
		pending_results.push_back(typed ? typed_res : r);
		sent++;
		idle_gap();
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_tag(input logic [7:0] v);
		start <= 1'b0;
		@(posedge clk);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_PREFIX);
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tag = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic item_t random_item(bit fill);
		item_t it;
		int r;
		logic [7:0] s;
		it.command = CMD_REGISTER;
		it.value = $urandom;
		it.handle = $urandom;
		if (fill)
			return it;
		r = $urandom_range(0, 99);
		it.command = r < 40 ? CMD_REGISTER : r < 70 ? CMD_RESOLVE : r < 99 ? CMD_RELEASE : CMD_CLEAR;
		r = $urandom_range(0, 99);
		if (r < 50)
			it.value = $urandom_range(0, 31);
		else if (r < 60)
			it.value = '1;
		else if (r < 65)
			it.value = '0;
		s = 8'($urandom);
		for (int i = 0; i < 8 && !shadow_used[s]; i++)
			s = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 60)
			it.handle = pack_handle(s, shadow_gen[s]);
		else if (r < 75)
			it.handle = pack_handle(s, shadow_gen[s] + 16'($urandom_range(1, 2)));
		else if (r < 85)
			it.handle = {tag ^ 8'($urandom_range(1, 255)), shadow_gen[s], s};
		else if (r < 90)
			it.handle = pack_handle(s, 16'd0);
		return it;
	endfunction

	row_t rows [$];

	function automatic row_t mk(cmd_t op, logic [31:0] v, logic [31:0] h, bit typed,
			status_t st, logic [31:0] ho, logic [31:0] vo);
		row_t x;
		x.op = op;
		x.value = v;
		x.handle = h;
		x.typed = typed;
		x.res = '{st, ho, vo};
		return x;
	endfunction

	initial begin
		item_t it;
		logic [7:0] tags [4];
		tag = 8'd165;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_value[i] = '0;
			shadow_used[i] = 1'b0;
			shadow_gen[i] = 16'd1;
		end
		next_free = '0;

		rows.push_back(mk(CMD_REGISTER, 32'h1234_5678, 0, 1, ST_OK, 32'hA500_0100, 0));
		rows.push_back(mk(CMD_REGISTER, 32'h1234_5678, 0, 1, ST_OK, 32'hA500_0100, 0));
		rows.push_back(mk(CMD_REGISTER, 32'hFFFF_FFFF, '1, 1, ST_OK, 32'hA500_0101, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0100, 1, ST_OK, 0, 32'h1234_5678));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0101, 1, ST_OK, 0, 32'hFFFF_FFFF));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'h0000_0100, 1, ST_INVALID, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0000, 1, ST_INVALID, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0200, 1, ST_STALE, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_01FF, 1, ST_STALE, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hFFFF_FFFF, 1, ST_INVALID, 0, 0));
		rows.push_back(mk(CMD_RELEASE, '1, 32'hA500_0100, 1, ST_OK, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0100, 1, ST_STALE, 0, 0));
		rows.push_back(mk(CMD_RELEASE, 0, 32'hA500_0100, 1, ST_STALE, 0, 0));
		rows.push_back(mk(CMD_RELEASE, 0, 32'h0000_0000, 1, ST_INVALID, 0, 0));
		rows.push_back(mk(CMD_REGISTER, 32'h0000_0000, 0, 1, ST_OK, 32'hA500_0200, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0200, 1, ST_OK, 0, 0));
		rows.push_back(mk(CMD_CLEAR, '1, '1, 1, ST_OK, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA500_0200, 1, ST_STALE, 0, 0));
		rows.push_back(mk(CMD_REGISTER, 32'h0000_0007, 0, 0, ST_OK, 0, 0));
		rows.push_back(mk(CMD_REGISTER, 32'h8000_0001, 0, 0, ST_OK, 0, 0));
		rows.push_back(mk(CMD_RESOLVE, 0, 32'hA503_0001, 0, ST_OK, 0, 0));
		rows.push_back(mk(CMD_RELEASE, 0, 32'hA503_0000, 0, ST_OK, 0, 0));
		rows.push_back(mk(CMD_REGISTER, 32'h0000_0009, 0, 0, ST_OK, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			it.command = rows[i].op;
			it.value = rows[i].value;
			it.handle = rows[i].handle;
			send(it, rows[i].typed, rows[i].res);
		end

		tags[0] = 8'd0;
		tags[1] = 8'd255;
		tags[2] = 8'($urandom);
		tags[3] = 8'd165;
		for (int p = 0; p < 4; p++) begin
			write_tag(tags[p]);
			// run the table past full for the second and fourth settings
			if (p == 1 || p == 3)
				for (int n = 0; n < 262; n++)
					send(random_item(1), 0, '0);
			for (int n = 0; n < 300; n++) begin
				if (n == 150) begin
					start <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				send(random_item(0), 0, '0);
			end
		end

		start <= 1'b0;
		drain();
		$display("sent %0d commands, checked %0d results over four prefix settings",
			sent, checked);
		$display("exhausted %0d, stale %0d, invalid %0d", exhausted_seen, stale_seen,
			invalid_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
rtl/core/ght_pkg.sv
rtl/core/ght_front.sv
rtl/core/ght_queue.sv
rtl/core/ght_back.sv
rtl/core/generational_handle_table_unit.sv
sim/generational_handle_table_unit_tb.sv
